// ===== sv/fts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the frame timing statistics unit: payload
// structs, sequencer states, register indexes and fixed-point scale factors.
// ----------------------------------------------------------------------------
package fts_pkg;

   // Field widths
   localparam int FT_W       = 24;
   localparam int NA_W       = 16;
   localparam int GAP_W      = 24;
   localparam int MINF_W     = 11;
   localparam int SF_W       = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_W      = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAMES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STUTTER_FACTOR = 2'd2;

   // Register reset values
   localparam logic [GAP_W-1:0]  GAP_LIMIT_RST      = 24'd1024000;
   localparam logic [MINF_W-1:0] MIN_FRAMES_RST     = 11'd30;
   localparam logic [SF_W-1:0]   STUTTER_FACTOR_RST = 8'd40;

   // Scale factors: 1000 ms * 1024 * 256 and 1000 ms * 1024 * 16
   localparam logic [DIV_W-1:0] FPS_SCALE  = 64'd262144000;
   localparam logic [DIV_W-1:0] NPS_SCALE  = 64'd16384000;
   localparam logic [DIV_W-1:0] STUT_SCALE = 64'd25600;
   localparam logic [DIV_W-1:0] MAX28      = 64'hFFFFFFF;
   localparam logic [DIV_W-1:0] MAX32      = 64'hFFFFFFFF;

   // Reciprocal multipliers for n/100 and n/1000 (exact for n up to 4096)
   localparam logic [31:0] DIV100_MUL  = 32'd5243;
   localparam int          DIV100_SH   = 19;
   localparam logic [31:0] DIV1000_MUL = 32'd8389;
   localparam int          DIV1000_SH  = 23;

   typedef struct packed {
      logic [FT_W-1:0] frame_time;
      logic [NA_W-1:0] note_activations;
   } fts_req_type;

   typedef struct packed {
      logic [23:0] avg_frame_time;
      logic [27:0] frames_per_second;
      logic [31:0] notes_per_second;
      logic [23:0] frame_time_stddev;
      logic [27:0] low_1pct_fps;
      logic [27:0] low_01pct_fps;
      logic [14:0] stutter_percent;
   } fts_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OLD_RD,
      S_OLD_LAT,
      S_REMOVE,
      S_INS_SETUP,
      S_INSERT,
      S_INS_LAST,
      S_CHECK,
      S_WIN_SETUP,
      S_WIN,
      S_SUM_SETUP,
      S_SUM,
      S_MEAN_GO,
      S_DIV,
      S_MEAN_GOT,
      S_THR_GOT,
      S_DEV_SETUP,
      S_DEV,
      S_VAR_GOT,
      S_VAR_ADJ,
      S_SQRT,
      S_AVG_GOT,
      S_FPS_GOT,
      S_NPS_MUL,
      S_NPS_GO,
      S_NPS_GOT,
      S_LOW1_GOT,
      S_LOW2_GOT,
      S_STUT_GOT,
      S_OUT
   } fts_state_type;

   // Clamp a quotient to the 28-bit FPS range
   function automatic logic [27:0] sat28(input logic [DIV_W-1:0] v);
      sat28 = (v > MAX28) ? 28'hFFFFFFF : v[27:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/frame_timing_statistics_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_timing_statistics_unit
// Frame time ring, sorted copy and activation ring with one shared
// restoring divider and an iterative square root under a sequencer.
// ----------------------------------------------------------------------------
// Each frame transfer stores its activation count and, if the frame time is
// nonzero and within gap_limit, stores the frame time in the long ring and in
// a sorted copy. Once the ring holds min_frames entries, one result follows
// each stored frame. The block takes one frame at a time; req_ready is low
// while a frame is processed. A stored frame takes a remove pass over the
// sorted memory once the ring is full and an insert pass; a frame that
// yields a result adds the recent window walk, sum and deviation passes
// and nine divisions on the shared divider. A rejected frame leaves the
// block idle, ready for the next frame. A finished result waits in the
// output register while the next frame is taken. Memories need no
// clearing pass: no entry is read before written.
// ----------------------------------------------------------------------------
module frame_timing_statistics_unit #(
   parameter int RING_DEPTH    = 1024,
   parameter int RECENT_WINDOW = 64
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  fts_pkg::fts_req_type                     req_data,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output fts_pkg::fts_rsp_type                     rsp_data,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire [fts_pkg::CSR_IDX_W-1:0]             csr_index,
   input  wire [fts_pkg::CSR_DATA_W-1:0]            csr_data
);

   localparam int FT_W   = fts_pkg::FT_W;
   localparam int NA_W   = fts_pkg::NA_W;
   localparam int DIV_W  = fts_pkg::DIV_W;
   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int AIDX_W = (RECENT_WINDOW > 1) ? $clog2(RECENT_WINDOW) : 1;
   localparam int ACNT_W = $clog2(RECENT_WINDOW + 1);
   localparam int WSUM_W = FT_W + ACNT_W;
   localparam int TOT_W  = NA_W + ACNT_W;
   localparam int S_W    = FT_W + CNT_W;
   localparam int PR_W   = 2 * CNT_W;

   localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
   localparam logic [AIDX_W-1:0] A_LAST   = AIDX_W'(RECENT_WINDOW - 1);
   localparam logic [ACNT_W-1:0] A_MAX    = ACNT_W'(RECENT_WINDOW);

   // Memories
   logic [FT_W-1:0] frame_ring  [RING_DEPTH];
   logic [FT_W-1:0] sorted_mem  [RING_DEPTH];
   logic [NA_W-1:0] act_ring    [RECENT_WINDOW];

   logic [FT_W-1:0]   fr_rdata_ff, sw_rdata_ff;
   logic [NA_W-1:0]   ar_rdata_ff;
   logic [IDX_W-1:0]  fr_raddr, sw_waddr;
   logic              fr_we, sw_we, ar_we;
   logic [FT_W-1:0]   sw_wdata;

   // Sequencer and datapath registers
   fts_pkg::fts_state_type state_ff, state_in, ret_ff, ret_in;
   logic [fts_pkg::GAP_W-1:0]  gap_limit_ff;
   logic [fts_pkg::MINF_W-1:0] min_frames_ff;
   logic [fts_pkg::SF_W-1:0]   stutter_factor_ff;
   logic [FT_W-1:0]   ft_ff, ft_in, old_ff, old_in;
   logic [IDX_W-1:0]  frame_head_ff, frame_head_in;
   logic [CNT_W-1:0]  frame_count_ff, frame_count_in;
   logic [AIDX_W-1:0] act_head_ff, act_head_in;
   logic [ACNT_W-1:0] act_count_ff, act_count_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  addr_ff, addr_in, rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AIDX_W-1:0] aaddr_ff, aaddr_in;
   logic [ACNT_W-1:0] aleft_ff, aleft_in;
   logic              ard_vld_ff, ard_vld_in;
   logic [ACNT_W-1:0] fcnt_ff, fcnt_in, ncnt_ff, ncnt_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [TOT_W-1:0]  tot_ff, tot_in;
   logic [S_W-1:0]    s_ff, s_in, sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic [CNT_W-1:0]  k1_ff, k1_in, k2_ff, k2_in, lo1_ff, lo1_in, lo2_ff, lo2_in;
   logic [FT_W-1:0]   m_ff, m_in, t2_ff, t2_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic [FT_W-1:0]   dd_ff, dd_in;
   logic              dvld_ff, dvld_in, sqvld_ff, sqvld_in;
   logic [2*FT_W-1:0] sq_ff, sq_in;
   logic [DIV_W-1:0]  d_ff, d_in, q_ff, q_in;
   logic [CNT_W-1:0]  stut_ff, stut_in;
   logic [PR_W-1:0]   pa_ff, pa_in, pb_ff, pb_in;
   logic [DIV_W-1:0]  sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [DIV_W-1:0]  np_ff, np_in, dn_ff, dn_in;
   logic [DIV_W-1:0]  dnum_ff, dnum_in, dden_ff, dden_in, drem_ff, drem_in;
   logic [5:0]        dcnt_ff, dcnt_in;
   fts_pkg::fts_rsp_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == fts_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign ar_we     = req_valid && req_ready;
   assign fr_raddr  = (state_ff == fts_pkg::S_OLD_RD) ? frame_head_ff : addr_ff;

   // Memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_ring[frame_head_ff] <= ft_ff;
      end
      fr_rdata_ff <= frame_ring[fr_raddr];
   end

   always_ff @(posedge clock) begin
      if (sw_we) begin
         sorted_mem[sw_waddr] <= sw_wdata;
      end
      sw_rdata_ff <= sorted_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (ar_we) begin
         act_ring[act_head_ff] <= req_data.note_activations;
      end
      ar_rdata_ff <= act_ring[aaddr_ff];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff      <= fts_pkg::GAP_LIMIT_RST;
         min_frames_ff     <= fts_pkg::MIN_FRAMES_RST;
         stutter_factor_ff <= fts_pkg::STUTTER_FACTOR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            fts_pkg::CSR_GAP_LIMIT: begin
               gap_limit_ff <= csr_data[fts_pkg::GAP_W-1:0];
            end
            fts_pkg::CSR_MIN_FRAMES: begin
               min_frames_ff <= csr_data[fts_pkg::MINF_W-1:0];
            end
            fts_pkg::CSR_STUTTER_FACTOR: begin
               stutter_factor_ff <= csr_data[fts_pkg::SF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // State and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fts_pkg::S_IDLE;
         ret_ff         <= fts_pkg::S_IDLE;
         frame_head_ff  <= '0;
         frame_count_ff <= '0;
         act_head_ff    <= '0;
         act_count_ff   <= '0;
         rd_vld_ff      <= 1'b0;
         ard_vld_ff     <= 1'b0;
         dvld_ff        <= 1'b0;
         sqvld_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ret_ff         <= ret_in;
         frame_head_ff  <= frame_head_in;
         frame_count_ff <= frame_count_in;
         act_head_ff    <= act_head_in;
         act_count_ff   <= act_count_in;
         rd_vld_ff      <= rd_vld_in;
         ard_vld_ff     <= ard_vld_in;
         dvld_ff        <= dvld_in;
         sqvld_ff       <= sqvld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      ft_ff       <= ft_in;
      old_ff      <= old_in;
      found_ff    <= found_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      left_ff     <= left_in;
      aaddr_ff    <= aaddr_in;
      aleft_ff    <= aleft_in;
      fcnt_ff     <= fcnt_in;
      ncnt_ff     <= ncnt_in;
      wsum_ff     <= wsum_in;
      tot_ff      <= tot_in;
      s_ff        <= s_in;
      sum1_ff     <= sum1_in;
      sum2_ff     <= sum2_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      lo1_ff      <= lo1_in;
      lo2_ff      <= lo2_in;
      m_ff        <= m_in;
      r_ff        <= r_in;
      t2_ff       <= t2_in;
      dd_ff       <= dd_in;
      sq_ff       <= sq_in;
      d_ff        <= d_in;
      q_ff        <= q_in;
      stut_ff     <= stut_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      sx_ff       <= sx_in;
      sres_ff     <= sres_in;
      sbit_ff     <= sbit_in;
      np_ff       <= np_in;
      dn_ff       <= dn_in;
      dnum_ff     <= dnum_in;
      dden_ff     <= dden_in;
      drem_ff     <= drem_in;
      dcnt_ff     <= dcnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state, memory controls and shared divider
   always_comb begin
      logic              full;
      logic [CNT_W-1:0]  c;
      logic [31:0]       fc32, k1w, k2w;
      logic [DIV_W-1:0]  dq, rem_sh, var_v, thr;

      full   = (frame_count_ff == DEPTH_C);
      c      = full ? CNT_W'(RING_DEPTH - 1) : frame_count_ff;
      fc32   = (32'(frame_count_ff) < 32'(RECENT_WINDOW)) ?
               32'(frame_count_ff) : 32'(RECENT_WINDOW);
      k1w    = (32'(frame_count_ff) * fts_pkg::DIV100_MUL) >> fts_pkg::DIV100_SH;
      k2w    = (32'(frame_count_ff) * fts_pkg::DIV1000_MUL) >> fts_pkg::DIV1000_SH;
      dq     = (dden_ff == '0) ? '0 : dnum_ff;
      rem_sh = {drem_ff[DIV_W-2:0], dnum_ff[DIV_W-1]};
      thr    = DIV_W'(s_ff) * DIV_W'(stutter_factor_ff);
      var_v  = q_ff - (((pa_ff < pb_ff) && (q_ff != '0)) ? DIV_W'(1) : DIV_W'(0));

      state_in       = state_ff;
      ret_in         = ret_ff;
      frame_head_in  = frame_head_ff;
      frame_count_in = frame_count_ff;
      act_head_in    = act_head_ff;
      act_count_in   = act_count_ff;
      ft_in          = ft_ff;
      old_in         = old_ff;
      found_in       = found_ff;
      addr_in        = addr_ff;
      rd_idx_in      = addr_ff;
      left_in        = left_ff;
      rd_vld_in      = 1'b0;
      aaddr_in       = aaddr_ff;
      aleft_in       = aleft_ff;
      ard_vld_in     = 1'b0;
      fcnt_in        = fcnt_ff;
      ncnt_in        = ncnt_ff;
      wsum_in        = wsum_ff;
      tot_in         = tot_ff;
      s_in           = s_ff;
      sum1_in        = sum1_ff;
      sum2_in        = sum2_ff;
      k1_in          = k1_ff;
      k2_in          = k2_ff;
      lo1_in         = lo1_ff;
      lo2_in         = lo2_ff;
      m_in           = m_ff;
      r_in           = r_ff;
      t2_in          = t2_ff;
      dd_in          = dd_ff;
      dvld_in        = 1'b0;
      sq_in          = sq_ff;
      sqvld_in       = 1'b0;
      d_in           = d_ff;
      q_in           = q_ff;
      stut_in        = stut_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      sx_in          = sx_ff;
      sres_in        = sres_ff;
      sbit_in        = sbit_ff;
      np_in          = np_ff;
      dn_in          = dn_ff;
      dnum_in        = dnum_ff;
      dden_in        = dden_ff;
      drem_in        = drem_ff;
      dcnt_in        = dcnt_ff;
      res_in         = res_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      fr_we          = 1'b0;
      sw_we          = 1'b0;
      sw_waddr       = rd_idx_ff;
      sw_wdata       = sw_rdata_ff;

      case (state_ff)
         // Take a frame, store its activation count, drop zero and gap frames
         fts_pkg::S_IDLE: begin
            if (req_valid) begin
               ft_in       = req_data.frame_time;
               act_head_in = (act_head_ff == A_LAST) ? '0 : AIDX_W'(act_head_ff + 1'b1);
               if (act_count_ff != A_MAX) begin
                  act_count_in = ACNT_W'(act_count_ff + 1'b1);
               end
               if ((req_data.frame_time != '0) &&
                   (req_data.frame_time <= gap_limit_ff)) begin
                  state_in = full ? fts_pkg::S_OLD_RD : fts_pkg::S_INS_SETUP;
               end
            end
         end
         // Fetch the frame time that is about to be overwritten
         fts_pkg::S_OLD_RD: begin
            state_in = fts_pkg::S_OLD_LAT;
         end
         fts_pkg::S_OLD_LAT: begin
            old_in   = fr_rdata_ff;
            addr_in  = '0;
            left_in  = DEPTH_C;
            found_in = 1'b0;
            state_in = fts_pkg::S_REMOVE;
         end
         // Remove the old value: shift every later entry down by one
         fts_pkg::S_REMOVE: begin
            if (left_ff != '0) begin
               rd_vld_in = 1'b1;
               addr_in   = IDX_W'(addr_ff + 1'b1);
               left_in   = CNT_W'(left_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               if (found_ff) begin
                  sw_we    = 1'b1;
                  sw_waddr = IDX_W'(rd_idx_ff - 1'b1);
               end else if (sw_rdata_ff == old_ff) begin
                  found_in = 1'b1;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = fts_pkg::S_INS_SETUP;
               end
            end
         end
         // Store the frame in the ring and start the sorted insert
         fts_pkg::S_INS_SETUP: begin
            fr_we         = 1'b1;
            frame_head_in = (frame_head_ff == LAST_IDX) ? '0 :
                            IDX_W'(frame_head_ff + 1'b1);
            if (!full) begin
               frame_count_in = CNT_W'(frame_count_ff + 1'b1);
            end
            if (c == '0) begin
               sw_we    = 1'b1;
               sw_waddr = '0;
               sw_wdata = ft_ff;
               state_in = fts_pkg::S_CHECK;
            end else begin
               addr_in  = IDX_W'(c - 1'b1);
               left_in  = c;
               state_in = fts_pkg::S_INSERT;
            end
         end
         // Walk down, move larger entries up one place, drop the new value in
         fts_pkg::S_INSERT: begin
            if (left_ff != '0) begin
               rd_vld_in = 1'b1;
               addr_in   = IDX_W'(addr_ff - 1'b1);
               left_in   = CNT_W'(left_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               sw_we    = 1'b1;
               sw_waddr = IDX_W'(rd_idx_ff + 1'b1);
               if (sw_rdata_ff > ft_ff) begin
                  if (rd_idx_ff == '0) begin
                     state_in = fts_pkg::S_INS_LAST;
                  end
               end else begin
                  sw_wdata = ft_ff;
                  state_in = fts_pkg::S_CHECK;
               end
            end
         end
         fts_pkg::S_INS_LAST: begin
            sw_we    = 1'b1;
            sw_waddr = '0;
            sw_wdata = ft_ff;
            state_in = fts_pkg::S_CHECK;
         end
         fts_pkg::S_CHECK: begin
            state_in = (32'(frame_count_ff) >= 32'(min_frames_ff)) ?
                       fts_pkg::S_WIN_SETUP : fts_pkg::S_IDLE;
         end
         // Recent window: newest frames and activations, walking backward
         fts_pkg::S_WIN_SETUP: begin
            fcnt_in  = ACNT_W'(fc32);
            ncnt_in  = act_count_ff;
            addr_in  = (frame_head_ff == '0) ? LAST_IDX : IDX_W'(frame_head_ff - 1'b1);
            left_in  = CNT_W'(fc32);
            aaddr_in = (act_head_ff == '0) ? A_LAST : AIDX_W'(act_head_ff - 1'b1);
            aleft_in = act_count_ff;
            wsum_in  = '0;
            tot_in   = '0;
            state_in = fts_pkg::S_WIN;
         end
         fts_pkg::S_WIN: begin
            if (left_ff != '0) begin
               rd_vld_in = 1'b1;
               addr_in   = (addr_ff == '0) ? LAST_IDX : IDX_W'(addr_ff - 1'b1);
               left_in   = CNT_W'(left_ff - 1'b1);
            end
            if (aleft_ff != '0) begin
               ard_vld_in = 1'b1;
               aaddr_in   = (aaddr_ff == '0) ? A_LAST : AIDX_W'(aaddr_ff - 1'b1);
               aleft_in   = ACNT_W'(aleft_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               wsum_in = WSUM_W'(wsum_ff + WSUM_W'(fr_rdata_ff));
            end
            if (ard_vld_ff) begin
               tot_in = TOT_W'(tot_ff + TOT_W'(ar_rdata_ff));
            end
            if ((left_ff == '0) && (aleft_ff == '0) && !rd_vld_ff && !ard_vld_ff) begin
               state_in = fts_pkg::S_SUM_SETUP;
            end
         end
         // Full sorted pass: total and the sums of the slowest entries
         fts_pkg::S_SUM_SETUP: begin
            k1_in    = (k1w == '0) ? CNT_W'(1) : CNT_W'(k1w);
            k2_in    = (k2w == '0) ? CNT_W'(1) : CNT_W'(k2w);
            lo1_in   = CNT_W'(frame_count_ff - ((k1w == '0) ? CNT_W'(1) : CNT_W'(k1w)));
            lo2_in   = CNT_W'(frame_count_ff - ((k2w == '0) ? CNT_W'(1) : CNT_W'(k2w)));
            s_in     = '0;
            sum1_in  = '0;
            sum2_in  = '0;
            addr_in  = '0;
            left_in  = frame_count_ff;
            state_in = fts_pkg::S_SUM;
         end
         fts_pkg::S_SUM: begin
            if (left_ff != '0) begin
               rd_vld_in = 1'b1;
               addr_in   = IDX_W'(addr_ff + 1'b1);
               left_in   = CNT_W'(left_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               s_in = S_W'(s_ff + S_W'(sw_rdata_ff));
               if (32'(rd_idx_ff) >= 32'(lo1_ff)) begin
                  sum1_in = S_W'(sum1_ff + S_W'(sw_rdata_ff));
               end
               if (32'(rd_idx_ff) >= 32'(lo2_ff)) begin
                  sum2_in = S_W'(sum2_ff + S_W'(sw_rdata_ff));
               end
            end
            if ((left_ff == '0) && !rd_vld_ff) begin
               state_in = fts_pkg::S_MEAN_GO;
            end
         end
         fts_pkg::S_MEAN_GO: begin
            dnum_in  = DIV_W'(s_ff);
            dden_in  = DIV_W'(frame_count_ff);
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_MEAN_GOT;
            state_in = fts_pkg::S_DIV;
         end
         // Shared divider: one quotient bit a cycle
         fts_pkg::S_DIV: begin
            if (rem_sh >= dden_ff) begin
               drem_in = rem_sh - dden_ff;
               dnum_in = {dnum_ff[DIV_W-2:0], 1'b1};
            end else begin
               drem_in = rem_sh;
               dnum_in = {dnum_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 6'd63) begin
               state_in = ret_ff;
            end
         end
         // Mean and remainder; next the stutter threshold over 16*n
         fts_pkg::S_MEAN_GOT: begin
            m_in     = dq[FT_W-1:0];
            r_in     = drem_ff[CNT_W-1:0];
            dnum_in  = thr;
            dden_in  = DIV_W'(frame_count_ff) << 4;
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_THR_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_THR_GOT: begin
            t2_in    = (dq[DIV_W-1:FT_W] != '0) ? '1 : dq[FT_W-1:0];
            state_in = fts_pkg::S_DEV_SETUP;
         end
         fts_pkg::S_DEV_SETUP: begin
            addr_in  = '0;
            left_in  = frame_count_ff;
            d_in     = '0;
            stut_in  = '0;
            state_in = fts_pkg::S_DEV;
         end
         // Squared deviations and stutter count, three-stage pipeline
         fts_pkg::S_DEV: begin
            if (left_ff != '0) begin
               rd_vld_in = 1'b1;
               addr_in   = IDX_W'(addr_ff + 1'b1);
               left_in   = CNT_W'(left_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               dd_in   = (sw_rdata_ff >= m_ff) ? (sw_rdata_ff - m_ff) : (m_ff - sw_rdata_ff);
               dvld_in = 1'b1;
               if (sw_rdata_ff > t2_ff) begin
                  stut_in = CNT_W'(stut_ff + 1'b1);
               end
            end
            sq_in    = (2*FT_W)'(dd_ff) * (2*FT_W)'(dd_ff);
            sqvld_in = dvld_ff;
            if (sqvld_ff) begin
               d_in = d_ff + DIV_W'(sq_ff);
            end
            if ((left_ff == '0) && !rd_vld_ff && !dvld_ff && !sqvld_ff) begin
               dnum_in  = d_ff;
               dden_in  = DIV_W'(frame_count_ff);
               drem_in  = '0;
               dcnt_in  = '0;
               ret_in   = fts_pkg::S_VAR_GOT;
               state_in = fts_pkg::S_DIV;
            end
         end
         // Correct the variance for the mean's remainder
         fts_pkg::S_VAR_GOT: begin
            q_in     = dq;
            pa_in    = PR_W'(frame_count_ff) * PR_W'(drem_ff[CNT_W-1:0]);
            pb_in    = PR_W'(r_ff) * PR_W'(r_ff);
            state_in = fts_pkg::S_VAR_ADJ;
         end
         fts_pkg::S_VAR_ADJ: begin
            sx_in    = var_v;
            sres_in  = '0;
            sbit_in  = DIV_W'(1) << (DIV_W - 2);
            state_in = fts_pkg::S_SQRT;
         end
         // Integer square root, two bits a cycle; then the window mean
         fts_pkg::S_SQRT: begin
            if (sbit_ff != '0) begin
               if (sx_ff >= (sres_ff + sbit_ff)) begin
                  sx_in   = sx_ff - (sres_ff + sbit_ff);
                  sres_in = (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_in = sres_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end else begin
               res_in.frame_time_stddev = sres_ff[FT_W-1:0];
               dnum_in  = DIV_W'(wsum_ff) + DIV_W'(fcnt_ff >> 1);
               dden_in  = DIV_W'(fcnt_ff);
               drem_in  = '0;
               dcnt_in  = '0;
               ret_in   = fts_pkg::S_AVG_GOT;
               state_in = fts_pkg::S_DIV;
            end
         end
         fts_pkg::S_AVG_GOT: begin
            res_in.avg_frame_time = dq[FT_W-1:0];
            dnum_in  = fts_pkg::FPS_SCALE * DIV_W'(fcnt_ff) + DIV_W'(wsum_ff >> 1);
            dden_in  = DIV_W'(wsum_ff);
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_FPS_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_FPS_GOT: begin
            res_in.frames_per_second = fts_pkg::sat28(dq);
            np_in    = fts_pkg::NPS_SCALE * DIV_W'(tot_ff);
            dn_in    = DIV_W'(wsum_ff) * DIV_W'(ncnt_ff);
            state_in = fts_pkg::S_NPS_MUL;
         end
         fts_pkg::S_NPS_MUL: begin
            np_in    = np_ff * DIV_W'(fcnt_ff);
            state_in = fts_pkg::S_NPS_GO;
         end
         fts_pkg::S_NPS_GO: begin
            dnum_in  = np_ff + (dn_ff >> 1);
            dden_in  = dn_ff;
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_NPS_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_NPS_GOT: begin
            res_in.notes_per_second = (dq > fts_pkg::MAX32) ? '1 : dq[31:0];
            dnum_in  = fts_pkg::FPS_SCALE * DIV_W'(k1_ff) + DIV_W'(sum1_ff >> 1);
            dden_in  = DIV_W'(sum1_ff);
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_LOW1_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_LOW1_GOT: begin
            res_in.low_1pct_fps = fts_pkg::sat28(dq);
            dnum_in  = fts_pkg::FPS_SCALE * DIV_W'(k2_ff) + DIV_W'(sum2_ff >> 1);
            dden_in  = DIV_W'(sum2_ff);
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_LOW2_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_LOW2_GOT: begin
            res_in.low_01pct_fps = fts_pkg::sat28(dq);
            dnum_in  = DIV_W'(stut_ff) * fts_pkg::STUT_SCALE + DIV_W'(frame_count_ff >> 1);
            dden_in  = DIV_W'(frame_count_ff);
            drem_in  = '0;
            dcnt_in  = '0;
            ret_in   = fts_pkg::S_STUT_GOT;
            state_in = fts_pkg::S_DIV;
         end
         fts_pkg::S_STUT_GOT: begin
            res_in.stutter_percent = dq[14:0];
            state_in = fts_pkg::S_OUT;
         end
         // Hand the result to the output register once it is free
         fts_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = fts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fts_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== dv/fts_checker.sv =====
// ----------------------------------------------------------------------------
// fts_checker
// Watches the frame, result and register channels of the frame timing
// statistics unit. Keeps its own copy of the rings, the sorted window and
// the registers. Predicts one result per stored frame once enough frames
// are held. Compares every result transfer field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module fts_checker #(
   parameter int RING_DEPTH    = 1024,
   parameter int RECENT_WINDOW = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  req_ready,
   input  fts_pkg::fts_req_type                 req_data,
   input  wire                                  rsp_valid,
   input  wire                                  rsp_ready,
   input  fts_pkg::fts_rsp_type                 rsp_data,
   input  wire                                  csr_valid,
   input  wire                                  csr_ready,
   input  wire [fts_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [fts_pkg::CSR_DATA_W-1:0]        csr_data,
   output int                                   errors,
   output int                                   pending,
   output int                                   results
);

   localparam longint unsigned FPS_K  = 64'd262144000;
   localparam longint unsigned NPS_K  = 64'd16384000;
   localparam longint unsigned LIM28  = 64'hFFFFFFF;
   localparam longint unsigned LIM32  = 64'hFFFFFFFF;

   // Model state
   logic [23:0] frames [RING_DEPTH];
   logic [23:0] ordered [RING_DEPTH];
   logic [15:0] notes [RECENT_WINDOW];
   int unsigned frame_wr, frame_fill, note_wr, note_fill;
   logic [23:0] gap_lim;
   logic [10:0] need_frames;
   logic [7:0]  stut_mul;

   fts_pkg::fts_rsp_type stats_q[$];

   function automatic longint unsigned fps_from(longint unsigned sum,
                                                longint unsigned cnt);
      longint unsigned v;
      if (sum == 0) return 0;
      v = (FPS_K * cnt + sum / 2) / sum;
      return (v > LIM28) ? LIM28 : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned slowest_fps(int unsigned k, int unsigned n);
      longint unsigned sum;
      sum = 0;
      for (int unsigned i = n - k; i < n; i++) sum += ordered[i];
      return fps_from(sum, k);
   endfunction

   // Store one frame and queue the statistics it produces
   task automatic take_frame(input logic [23:0] ft, input logic [15:0] na);
      int unsigned fcnt, ncnt, n, idx, k, stut, pos;
      longint unsigned wsum, tot, s, m, r, d, q, rem, var_v, nps, thr, den, dd;
      fts_pkg::fts_rsp_type st;
      wsum = 0; tot = 0; s = 0; d = 0;
      notes[note_wr] = na;
      note_wr = (note_wr + 1 >= RECENT_WINDOW) ? 0 : note_wr + 1;
      if (note_fill < RECENT_WINDOW) note_fill++;
      if (ft == 0 || ft > gap_lim) return;

      // Drop the overwritten entry from the sorted window when full
      if (frame_fill >= RING_DEPTH) begin
         for (pos = 0; pos < RING_DEPTH; pos++)
            if (ordered[pos] == frames[frame_wr]) break;
         for (int unsigned j = pos; j + 1 < RING_DEPTH; j++) ordered[j] = ordered[j + 1];
         n = RING_DEPTH - 1;
      end else begin
         n = frame_fill;
         frame_fill++;
      end
      pos = n;
      while (pos > 0 && ordered[pos - 1] > ft) begin
         ordered[pos] = ordered[pos - 1];
         pos--;
      end
      ordered[pos] = ft;
      frames[frame_wr] = ft;
      frame_wr = (frame_wr + 1 >= RING_DEPTH) ? 0 : frame_wr + 1;

      if (frame_fill < need_frames) return;

      fcnt = (frame_fill < RECENT_WINDOW) ? frame_fill : RECENT_WINDOW;
      idx = frame_wr;
      for (int unsigned i = 0; i < fcnt; i++) begin
         idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
         wsum += frames[idx];
      end
      ncnt = note_fill;
      idx = note_wr;
      for (int unsigned i = 0; i < ncnt; i++) begin
         idx = (idx == 0) ? RECENT_WINDOW - 1 : idx - 1;
         tot += notes[idx];
      end

      st.avg_frame_time = 24'((fcnt != 0) ? (wsum + fcnt / 2) / fcnt : 0);
      st.frames_per_second = 28'(fps_from(wsum, fcnt));
      nps = 0;
      if (ncnt != 0 && wsum != 0) begin
         den = wsum * ncnt;
         nps = (NPS_K * tot * fcnt + den / 2) / den;
         if (nps > LIM32) nps = LIM32;
      end
      st.notes_per_second = 32'(nps);

      // Whole-ring deviation with the mean remainder folded back in
      n = frame_fill;
      for (int unsigned i = 0; i < n; i++) s += ordered[i];
      m = s / n;
      r = s % n;
      for (int unsigned i = 0; i < n; i++) begin
         dd = (ordered[i] >= m) ? ordered[i] - m : m - ordered[i];
         d += dd * dd;
      end
      q = d / n;
      rem = d % n;
      var_v = q;
      if (longint'(n) * rem < r * r && var_v > 0) var_v--;
      st.frame_time_stddev = 24'(int_sqrt(var_v));

      k = n / 100;
      st.low_1pct_fps = 28'(slowest_fps((k != 0) ? k : 1, n));
      k = n / 1000;
      st.low_01pct_fps = 28'(slowest_fps((k != 0) ? k : 1, n));

      thr = s * stut_mul;
      stut = 0;
      for (int unsigned i = 0; i < n; i++)
         if (longint'(ordered[i]) * 16 * n > thr) stut++;
      st.stutter_percent = 15'((longint'(stut) * 25600 + n / 2) / n);
      stats_q = {stats_q, st};
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      fts_pkg::fts_rsp_type want;
      if (reset) begin
         frame_wr = 0; frame_fill = 0; note_wr = 0; note_fill = 0;
         gap_lim = fts_pkg::GAP_LIMIT_RST;
         need_frames = fts_pkg::MIN_FRAMES_RST;
         stut_mul = fts_pkg::STUTTER_FACTOR_RST;
         stats_q.delete();
         errors = 0;
         results = 0;
      end else begin
         // Compare a result transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            results++;
            if (stats_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transfer %h", $realtime, rsp_data);
            end else begin
               want = stats_q.pop_front();
               check_field("avg_frame_time", want.avg_frame_time, rsp_data.avg_frame_time);
               check_field("frames_per_second", want.frames_per_second,
                           rsp_data.frames_per_second);
               check_field("notes_per_second", want.notes_per_second,
                           rsp_data.notes_per_second);
               check_field("frame_time_stddev", want.frame_time_stddev,
                           rsp_data.frame_time_stddev);
               check_field("low_1pct_fps", want.low_1pct_fps, rsp_data.low_1pct_fps);
               check_field("low_01pct_fps", want.low_01pct_fps, rsp_data.low_01pct_fps);
               check_field("stutter_percent", want.stutter_percent,
                           rsp_data.stutter_percent);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fts_pkg::CSR_GAP_LIMIT:      gap_lim = csr_data[23:0];
               fts_pkg::CSR_MIN_FRAMES:     need_frames = csr_data[10:0];
               fts_pkg::CSR_STUTTER_FACTOR: stut_mul = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_frame(req_data.frame_time, req_data.note_activations);
      end
      pending = stats_q.size();
   end

endmodule

// ===== dv/frame_timing_statistics_unit_tb.sv =====
// ----------------------------------------------------------------------------
// frame_timing_statistics_unit_tb
// Drives frames and register writes into the frame timing statistics unit
// with random gaps and result stalls; the checker predicts and compares.
// Directed frames cover field extremes, zero and gap frames and register
// extremes, then random phases run with varied register settings.
// ----------------------------------------------------------------------------
module frame_timing_statistics_unit_tb;

   localparam int IDLE_WAIT   = 6000;
   localparam int STALL_LIMIT = 200000;

   // Register index past the end of the register list
   localparam logic [fts_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   fts_pkg::fts_req_type req_data;
   fts_pkg::fts_rsp_type rsp_data;
   logic [fts_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fts_pkg::CSR_DATA_W-1:0] csr_data;
   int errors, pending, results, frames_sent, quiet_cycles, rdy_hold;

   frame_timing_statistics_unit dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   fts_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .pending, .results
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 15);
      return $urandom_range(20, 200);
   endfunction

   // Toggle result ready in random stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rdy_hold <= 0;
      end else if (rdy_hold > 0) begin
         rdy_hold <= rdy_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(2) != 0);
         rdy_hold <= pick_gap();
      end
   end

   // Watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_frame(input logic [23:0] ft, input logic [15:0] na);
      repeat (pick_gap()) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data.frame_time = ft;
      req_data.note_activations = na;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frames_sent++;
   endtask

   task automatic write_reg(input logic [fts_pkg::CSR_IDX_W-1:0] idx,
                            input logic [23:0] val);
      @(negedge clock);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hold until every result has arrived and the block has settled
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic set_regs(input logic [23:0] gap, input logic [10:0] minf,
                           input logic [7:0] sf);
      drain();
      write_reg(fts_pkg::CSR_GAP_LIMIT, gap);
      write_reg(fts_pkg::CSR_MIN_FRAMES, 24'(minf));
      write_reg(fts_pkg::CSR_STUTTER_FACTOR, 24'(sf));
   endtask

   function automatic logic [23:0] rand_frame(input logic [23:0] gap);
      int p;
      p = $urandom_range(99);
      if (p < 55) return 24'(16000 + $urandom_range(0, 9000));
      if (p < 65) return 24'($urandom_range(1, 40));
      if (p < 75) return 24'($urandom);
      if (p < 83) return 24'd0;
      if (p < 91) return gap;
      return (gap == 24'hFFFFFF) ? gap : gap + 24'd1;
   endfunction

   initial begin
      logic [23:0] gap;
      logic [10:0] minf;
      logic [7:0]  sf;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      frames_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Widest gap limit, result on every stored frame, every frame a stutter
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      set_regs(24'hFFFFFF, 11'd0, 8'd0);
      send_frame(24'hFFFFFF, 16'hFFFF);
      send_frame(24'd1, 16'd0);
      send_frame(24'd0, 16'd12);
      send_frame(24'd8000, 16'd1);
      send_frame(24'hFFFFFF, 16'd0);
      // Narrowest gap limit
      set_regs(24'd1, 11'd1, 8'd255);
      send_frame(24'd1, 16'hFFFF);
      send_frame(24'd2, 16'd5);
      send_frame(24'd0, 16'd0);
      send_frame(24'd1, 16'd1);
      // Threshold above the ring size: no results
      set_regs(24'd1024000, 11'd2047, 8'd1);
      send_frame(24'd1024000, 16'd3);
      send_frame(24'd1024001, 16'd4);
      send_frame(24'd20000, 16'd7);
      set_regs(24'd20000, 11'd1025, 8'd40);
      send_frame(24'd20000, 16'd1);
      send_frame(24'd20001, 16'd2);

      // Random phases with varied register settings
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 0) begin
            gap = fts_pkg::GAP_LIMIT_RST;
            minf = fts_pkg::MIN_FRAMES_RST;
            sf = fts_pkg::STUTTER_FACTOR_RST;
         end else begin
            case ($urandom_range(3))
               0: gap = 24'hFFFFFF;
               1: gap = 24'($urandom_range(16000, 30000));
               default: gap = fts_pkg::GAP_LIMIT_RST;
            endcase
            case ($urandom_range(3))
               0: minf = 11'd1;
               1: minf = 11'd1025;
               default: minf = 11'($urandom_range(1, 40));
            endcase
            case ($urandom_range(3))
               0: sf = 8'd0;
               1: sf = 8'd255;
               default: sf = 8'($urandom_range(1, 60));
            endcase
         end
         set_regs(gap, minf, sf);
         for (int i = 0; i < 25; i++)
            send_frame(rand_frame(gap), 16'($urandom));
      end

      drain();
      $display("Sent %0d frames over several register settings; %0d results compared.",
               frames_sent, results);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/fts_pkg.sv
sv/frame_timing_statistics_unit.sv
dv/fts_checker.sv
dv/frame_timing_statistics_unit_tb.sv
